// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the command frame decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ACFD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ACFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/acfd_pkg.sv =====
// Constants, codes and the value parser of the ASCII command frame decoder.
package acfd_pkg;

  // item kinds on the input tuser
  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_ENCODER = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  // configuration register indexes
  localparam logic [7:0] REG_TOLERANCE = 8'd0;
  localparam logic [7:0] REG_SPEED     = 8'd1;

  // frame characters
  localparam logic [7:0] CHAR_PERIOD = 8'h2E;  // '.'
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  // command letters
  localparam logic [7:0] CMD_SERVO_ONE   = 8'h71;  // 'q'
  localparam logic [7:0] CMD_SERVO_TWO   = 8'h77;  // 'w'
  localparam logic [7:0] CMD_SERVO_THREE = 8'h65;  // 'e'
  localparam logic [7:0] CMD_ACT_ONE     = 8'h61;  // 'a'
  localparam logic [7:0] CMD_ACT_TWO     = 8'h73;  // 's'
  localparam logic [7:0] CMD_RACK        = 8'h64;  // 'd'

  localparam int unsigned FRAME_LEN = 5;
  localparam logic [2:0] LAST_BYTE_IDX = 3'(FRAME_LEN - 1);

  localparam logic signed [31:0] RACK_SCALE = 32'sd1000;

  // quadrature step for each 4-bit {previous AB, current AB} history
  localparam logic signed [1:0] QUAD_TABLE [16] = '{
    2'sd0, -2'sd1,  2'sd1,  2'sd0,
    2'sd1,  2'sd0,  2'sd0, -2'sd1,
   -2'sd1,  2'sd0,  2'sd0,  2'sd1,
    2'sd0,  2'sd1, -2'sd1,  2'sd0
  };

  // parser phases
  localparam logic [1:0] PH_BLANK  = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  // atoi over exactly three characters: blanks, optional sign, digits
  function automatic logic signed [10:0] parse_value(input logic [7:0] c0,
                                                     input logic [7:0] c1,
                                                     input logic [7:0] c2);
    logic [7:0] chars [3];
    logic [7:0] ch;
    logic [1:0] ph;
    logic       neg;
    logic       is_blank;
    logic       is_digit;
    logic [9:0] acc;
    chars[0] = c0;
    chars[1] = c1;
    chars[2] = c2;
    ph  = PH_BLANK;
    neg = 1'b0;
    acc = 10'd0;
    for (int i = 0; i < 3; i++) begin
      ch       = chars[i];
      is_blank = (ch == CHAR_SPACE) || (ch >= CHAR_TAB && ch <= CHAR_CR);
      is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
      case (ph)
        PH_BLANK: begin
          if (is_blank) begin
            ph = PH_BLANK;
          end else if (ch == CHAR_PLUS || ch == CHAR_MINUS) begin
            neg = (ch == CHAR_MINUS);
            ph  = PH_DIGITS;
          end else if (is_digit) begin
            acc = 10'(ch - CHAR_ZERO);
            ph  = PH_DIGITS;
          end else begin
            ph = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            acc = 10'(acc * 10'd10) + 10'(ch - CHAR_ZERO);
          end else begin
            ph = PH_DONE;
          end
        end
        default: ph = PH_DONE;
      endcase
    end
    return neg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});
  endfunction

endpackage

// ===== hdl/ascii_command_frame_decoder_unit.sv =====
// ASCII command frame decoder with quadrature position counter and rack drive.
//
// Each request on the input stream is one item: a received serial byte, an
// encoder A/B sample or a control tick (kind in s_axis_tuser). Bytes build
// 5-byte frames "Xnnn."; the letter picks servo angle q/w/e, actuator a/s
// or rack move d (target = position + 1000 * value), the three middle
// characters are read like atoi. A frame not ending in '.' starts a hunt
// that drops bytes up to and including the next '.'. Encoder samples step
// the position through the quadrature table; ticks set the bang-bang drive
// from target - position against the tolerance. Every item gives exactly
// one result request carrying all outputs plus frame_accepted and hunting.
// Timing: one item per clock sustained while m_axis_tready is high; each
// item passes the input register, then the state/result register. s_axis_tready depends
// combinationally on m_axis_tready through the one-deep input register.
// The state registers themselves are the result register: they only change
// when a result is loaded, so they always hold what m_axis_tdata shows.
// Configuration writes (cfg_*) are always accepted; write them while idle.
`include "assert_macros.svh"

module ascii_command_frame_decoder_unit #(
  parameter int unsigned CFG_INDEX_W = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [15:0]            s_axis_tdata,   // [7:0] rx_byte, [9:8] encoder_ab, rest 0
  input  logic [1:0]             s_axis_tuser,   // [1:0] operation
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [127:0]           m_axis_tdata,   // [10:0] servo_one, [21:11] servo_two,
                                                 // [32:22] servo_three, [40:33] actuator_one,
                                                 // [48:41] actuator_two, [57:49] rack_drive,
                                                 // [89:58] position, [121:90] target, rest 0
  output logic [1:0]             m_axis_tuser,   // [0] frame_accepted, [1] hunting
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_data
);

  // ---------------- configuration ----------------
  logic [15:0] position_tolerance;
  logic [7:0]  drive_speed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      position_tolerance <= 16'd20;
      drive_speed        <= 8'd100;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_INDEX_W'(acfd_pkg::REG_TOLERANCE)) begin
        position_tolerance <= cfg_data;
      end else if (cfg_index == CFG_INDEX_W'(acfd_pkg::REG_SPEED)) begin
        drive_speed <= cfg_data[7:0];
      end
    end
  end

  // ---------------- input register ----------------
  logic       in_valid;
  logic [1:0] in_op;
  logic [7:0] in_byte;
  logic [1:0] in_ab;
  logic       out_valid;
  logic       advance;

  // an item moves on when the result slot is empty or being drained
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op   <= s_axis_tuser;
      in_byte <= s_axis_tdata[7:0];
      in_ab   <= s_axis_tdata[9:8];
    end
  end

  // ---------------- state / result registers ----------------
  logic [7:0]         frame_bytes [4];   // letter + 3 value chars; '.' is checked live
  logic [2:0]         byte_count;
  logic               hunt_flag;
  logic [3:0]         encoder_history;
  logic [31:0]        position_count;
  logic [31:0]        target_count;
  logic signed [10:0] servo_angles [3];
  logic [7:0]         actuator_values [2];
  logic signed [8:0]  drive_level;
  logic               frame_accepted;

  logic [2:0]         byte_count_next;
  logic               hunt_flag_next;
  logic [3:0]         encoder_history_next;
  logic [31:0]        position_count_next;
  logic [31:0]        target_count_next;
  logic signed [10:0] servo_angles_next [3];
  logic [7:0]         actuator_values_next [2];
  logic signed [8:0]  drive_level_next;
  logic               frame_accepted_next;
  logic               frame_wr;

  // frame decode
  logic signed [10:0] cmd_value;
  logic [31:0]        cmd_value_ext;
  logic [31:0]        rack_offset;

  assign cmd_value     = acfd_pkg::parse_value(frame_bytes[1], frame_bytes[2], frame_bytes[3]);
  assign cmd_value_ext = {{21{cmd_value[10]}}, cmd_value};
  assign rack_offset   = 32'($signed(cmd_value_ext) * acfd_pkg::RACK_SCALE);

  // drive error, exact at 33 bits
  logic signed [32:0] drive_err;
  logic [32:0]        drive_mag;
  logic signed [1:0]  quad_step;
  logic [3:0]         history_shift;

  assign drive_err = $signed({target_count[31], target_count})
                   - $signed({position_count[31], position_count});
  assign drive_mag = drive_err[32] ? 33'(-drive_err) : 33'(drive_err);

  assign history_shift = {encoder_history[1:0], in_ab};
  assign quad_step     = acfd_pkg::QUAD_TABLE[history_shift];

  always_comb begin
    byte_count_next      = byte_count;
    hunt_flag_next       = hunt_flag;
    encoder_history_next = encoder_history;
    position_count_next  = position_count;
    target_count_next    = target_count;
    servo_angles_next    = servo_angles;
    actuator_values_next = actuator_values;
    drive_level_next     = drive_level;
    frame_accepted_next  = 1'b0;
    frame_wr             = 1'b0;

    unique case (in_op)
      acfd_pkg::OP_BYTE: begin
        if (hunt_flag) begin
          // drop everything up to and including the next period
          if (in_byte == acfd_pkg::CHAR_PERIOD) begin
            hunt_flag_next  = 1'b0;
            byte_count_next = 3'd0;
          end
        end else if (byte_count == acfd_pkg::LAST_BYTE_IDX) begin
          byte_count_next = 3'd0;
          if (in_byte == acfd_pkg::CHAR_PERIOD) begin
            frame_accepted_next = 1'b1;
            unique case (frame_bytes[0])
              acfd_pkg::CMD_SERVO_ONE:   servo_angles_next[0] = cmd_value;
              acfd_pkg::CMD_SERVO_TWO:   servo_angles_next[1] = cmd_value;
              acfd_pkg::CMD_SERVO_THREE: servo_angles_next[2] = cmd_value;
              acfd_pkg::CMD_ACT_ONE:     actuator_values_next[0] = cmd_value[7:0];
              acfd_pkg::CMD_ACT_TWO:     actuator_values_next[1] = cmd_value[7:0];
              acfd_pkg::CMD_RACK:        target_count_next = position_count + rack_offset;
              default: ;  // unknown letter: accepted, no effect
            endcase
          end else begin
            hunt_flag_next = 1'b1;
          end
        end else begin
          frame_wr        = 1'b1;
          byte_count_next = byte_count + 3'd1;
        end
      end
      acfd_pkg::OP_ENCODER: begin
        encoder_history_next = history_shift;
        position_count_next  = position_count + {{30{quad_step[1]}}, quad_step};
      end
      acfd_pkg::OP_TICK: begin
        if (drive_mag > {17'd0, position_tolerance}) begin
          // position above target drives positive
          drive_level_next = drive_err[32] ? $signed({1'b0, drive_speed})
                                           : -$signed({1'b0, drive_speed});
        end else begin
          drive_level_next = 9'sd0;
        end
      end
      default: ;  // unused kind: state unchanged
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid          <= 1'b0;
      byte_count         <= 3'd0;
      hunt_flag          <= 1'b0;
      encoder_history    <= 4'd0;
      position_count     <= 32'd0;
      target_count       <= 32'd0;
      servo_angles[0]    <= 11'sd0;
      servo_angles[1]    <= 11'sd0;
      servo_angles[2]    <= 11'sd0;
      actuator_values[0] <= 8'd1;
      actuator_values[1] <= 8'd1;
      drive_level        <= 9'sd0;
      frame_accepted     <= 1'b0;
    end else begin
      if (advance) begin
        out_valid       <= 1'b1;
        byte_count      <= byte_count_next;
        hunt_flag       <= hunt_flag_next;
        encoder_history <= encoder_history_next;
        position_count  <= position_count_next;
        target_count    <= target_count_next;
        servo_angles    <= servo_angles_next;
        actuator_values <= actuator_values_next;
        drive_level     <= drive_level_next;
        frame_accepted  <= frame_accepted_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // frame buffer: payload only
  always_ff @(posedge clk) begin
    if (advance && frame_wr) begin
      frame_bytes[byte_count[1:0]] <= in_byte;
    end
  end

  // ---------------- result stream ----------------
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0,
                          target_count,
                          position_count,
                          drive_level,
                          actuator_values[1],
                          actuator_values[0],
                          servo_angles[2],
                          servo_angles[1],
                          servo_angles[0]};
  assign m_axis_tuser  = {hunt_flag, frame_accepted};

  // ---------------- assertions ----------------
  `ACFD_ASSERT_IMPL(a_hunt_count_zero, clk, rst, hunt_flag, byte_count == 3'd0,
                    "hunt active with a partial frame count")
  `ACFD_ASSERT_IMPL(a_accept_not_hunting, clk, rst, out_valid && frame_accepted, !hunt_flag,
                    "frame accepted while hunting")
  `ACFD_ASSERT_NEXT(a_hunt_holds, clk, rst,
                    advance && hunt_flag && in_op == acfd_pkg::OP_BYTE
                      && in_byte != acfd_pkg::CHAR_PERIOD,
                    hunt_flag && !frame_accepted,
                    "hunt left without a period")
  `ACFD_ASSERT_NEXT(a_encoder_step, clk, rst, advance && in_op == acfd_pkg::OP_ENCODER,
                    (position_count - $past(position_count)) == 32'd0
                      || (position_count - $past(position_count)) == 32'd1
                      || (position_count - $past(position_count)) == 32'hFFFF_FFFF,
                    "encoder sample moved position by more than one count")

endmodule
